>>> rtl/sha256md_pkg.sv
`timescale 1ns / 1ps

package sha256md_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumHash   = 8;
  localparam int unsigned NumSched  = 16;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned LenW      = 64;
  localparam int unsigned VbitsW    = 6;

  localparam logic [3:0] FillLenHi   = 4'd14;
  localparam logic [3:0] FillLast    = 4'd15;
  localparam logic [5:0] RoundLast   = 6'd63;
  localparam logic [2:0] IdxLast     = 3'd7;
  localparam logic [5:0] FullVbits   = 6'd32;
  localparam logic [31:0] PadOneWord = 32'h8000_0000;

  localparam logic [31:0] RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [NumHash] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_ONE,
    PH_ZERO,
    PH_LEN_LO,
    PH_DONE
  } pad_phase_e;

  typedef struct packed {
    logic        shift;
    logic        load;
    logic [31:0] word;
  } sched_ctrl_t;

  typedef struct packed {
    logic init;
    logic start;
  } rnd_ctrl_t;

  typedef struct packed {
    logic active;
    logic done;
  } rnd_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

>>> rtl/sha256md_sched.sv
`timescale 1ns / 1ps

module sha256md_sched (
  input  logic                     clk_i,
  input  sha256md_pkg::sched_ctrl_t ctrl_i,
  output logic [31:0]              wt_o
);

  logic [31:0] w_q [sha256md_pkg::NumSched];
  logic [31:0] expand;

  // window holds w[t] .. w[t+15]; the new word is w[t+16]
  assign expand = sha256md_pkg::ssig1(w_q[14]) + w_q[9] +
                  sha256md_pkg::ssig0(w_q[1]) + w_q[0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      for (int i = 0; i < sha256md_pkg::NumSched - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[sha256md_pkg::NumSched-1] <= ctrl_i.load ? ctrl_i.word : expand;
    end
  end

  assign wt_o = w_q[0];

endmodule

>>> rtl/sha256md_round.sv
`timescale 1ns / 1ps

module sha256md_round (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sha256md_pkg::rnd_ctrl_t ctrl_i,
  input  logic [31:0]             wt_i,
  output sha256md_pkg::rnd_stat_t stat_o,
  output logic [31:0]             hash_o [sha256md_pkg::NumHash]
);

  logic [31:0] hash_q [sha256md_pkg::NumHash];
  logic [31:0] v_q    [sha256md_pkg::NumHash];
  logic [5:0]  round_q;
  logic        active_q;
  logic        final_q;

  logic [31:0] t1, t2, ch, maj;

  always_comb begin
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + sha256md_pkg::bsig1(v_q[4]) + ch +
          sha256md_pkg::RoundK[round_q] + wt_i;
    t2  = sha256md_pkg::bsig0(v_q[0]) + maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      final_q  <= 1'b0;
      round_q  <= '0;
      for (int i = 0; i < sha256md_pkg::NumHash; i++) begin
        hash_q[i] <= sha256md_pkg::InitHash[i];
        v_q[i]    <= '0;
      end
    end else begin
      if (ctrl_i.start) begin
        active_q <= 1'b1;
        round_q  <= '0;
        for (int i = 0; i < sha256md_pkg::NumHash; i++) begin
          v_q[i] <= hash_q[i];
        end
      end else if (active_q) begin
        v_q[7] <= v_q[6];
        v_q[6] <= v_q[5];
        v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2];
        v_q[2] <= v_q[1];
        v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
        round_q <= round_q + 6'd1;
        if (round_q == sha256md_pkg::RoundLast) begin
          active_q <= 1'b0;
          final_q  <= 1'b1;
        end
      end
      if (final_q) begin
        final_q <= 1'b0;
        for (int i = 0; i < sha256md_pkg::NumHash; i++) begin
          hash_q[i] <= hash_q[i] + v_q[i];
        end
      end else if (ctrl_i.init) begin
        for (int i = 0; i < sha256md_pkg::NumHash; i++) begin
          hash_q[i] <= sha256md_pkg::InitHash[i];
        end
      end
    end
  end

  assign stat_o.active = active_q;
  assign stat_o.done   = final_q;
  assign hash_o        = hash_q;

endmodule

>>> rtl/sha256_message_digest_top.sv
`timescale 1ns / 1ps
// a word that does not complete a 16-word block is taken at once; unless it is the last, input stays ready
// a word that completes a block starts the rounds and then the hash update; input is not ready until they finish
// last word: 2 to 17 padding words, one or two compressions, then 8 digest items
// throughput is bounded by the single round unit; input is not ready while a block is compressed
// reset loads the initial hash and clears length, fill and control; schedule is not cleared

module sha256_message_digest_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] word_i,
  input  logic [5:0]  valid_bits_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha256md_pkg::state_e     state_q, state_d;
  sha256md_pkg::pad_phase_e phase_q, phase_d;
  logic [3:0]               fill_q, fill_d;
  logic [63:0]              len_q, len_d;
  logic [2:0]               idx_q, idx_d;

  sha256md_pkg::sched_ctrl_t sched_ctrl;
  sha256md_pkg::rnd_ctrl_t   rnd_ctrl;
  sha256md_pkg::rnd_stat_t   rnd_stat;
  logic [31:0]               wt;
  logic [31:0]               hash [sha256md_pkg::NumHash];

  logic        in_acc, out_acc, push, wrap;
  logic [5:0]  vbits;
  logic [31:0] push_word, keep, part_word;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // partial valid counts only count on the final word
  assign vbits = (valid_bits_i > sha256md_pkg::FullVbits || !last_i) ?
                 sha256md_pkg::FullVbits : valid_bits_i;
  assign keep      = ~(32'hffff_ffff >> vbits[4:0]);
  assign part_word = (word_i & keep) | (sha256md_pkg::PadOneWord >> vbits[4:0]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha256md_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (wrap)        state_d = sha256md_pkg::ST_COMP;
          else if (last_i) state_d = sha256md_pkg::ST_PAD;
        end
      end
      sha256md_pkg::ST_PAD: begin
        if (wrap) state_d = sha256md_pkg::ST_COMP;
      end
      sha256md_pkg::ST_COMP: begin
        if (rnd_stat.done) begin
          if (phase_q == sha256md_pkg::PH_DONE)      state_d = sha256md_pkg::ST_OUT;
          else if (phase_q == sha256md_pkg::PH_NONE) state_d = sha256md_pkg::ST_IDLE;
          else                                       state_d = sha256md_pkg::ST_PAD;
        end
      end
      sha256md_pkg::ST_OUT: begin
        if (out_acc && idx_q == sha256md_pkg::IdxLast) state_d = sha256md_pkg::ST_IDLE;
      end
      default: state_d = sha256md_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    push        = 1'b0;
    push_word   = '0;
    unique case (state_q)
      sha256md_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        push       = in_valid_i;
        push_word  = (last_i && vbits != sha256md_pkg::FullVbits) ? part_word : word_i;
      end
      sha256md_pkg::ST_PAD: begin
        push = 1'b1;
        case (phase_q)
          sha256md_pkg::PH_ONE:    push_word = sha256md_pkg::PadOneWord;
          sha256md_pkg::PH_ZERO:   push_word = (fill_q == sha256md_pkg::FillLenHi) ?
                                               len_q[63:32] : '0;
          sha256md_pkg::PH_LEN_LO: push_word = len_q[31:0];
          default:                 push_word = '0;
        endcase
      end
      sha256md_pkg::ST_COMP: begin
        push = 1'b0;
      end
      sha256md_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign wrap = push && fill_q == sha256md_pkg::FillLast;

  always_comb begin
    phase_d = phase_q;
    fill_d  = push ? fill_q + 4'd1 : fill_q;
    len_d   = len_q;
    idx_d   = idx_q;
    if (in_acc) begin
      len_d = len_q + {58'd0, vbits};
      if (last_i) begin
        phase_d = (vbits == sha256md_pkg::FullVbits) ? sha256md_pkg::PH_ONE
                                                     : sha256md_pkg::PH_ZERO;
      end
    end
    if (state_q == sha256md_pkg::ST_PAD) begin
      case (phase_q)
        sha256md_pkg::PH_ONE:  phase_d = sha256md_pkg::PH_ZERO;
        sha256md_pkg::PH_ZERO: begin
          if (fill_q == sha256md_pkg::FillLenHi) phase_d = sha256md_pkg::PH_LEN_LO;
        end
        sha256md_pkg::PH_LEN_LO: phase_d = sha256md_pkg::PH_DONE;
        default: phase_d = phase_q;
      endcase
    end
    if (out_acc) begin
      idx_d = idx_q + 3'd1;
      if (idx_q == sha256md_pkg::IdxLast) begin
        phase_d = sha256md_pkg::PH_NONE;
        len_d   = '0;
        fill_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256md_pkg::ST_IDLE;
      phase_q <= sha256md_pkg::PH_NONE;
      fill_q  <= '0;
      len_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
    end
  end

  // schedule shifts on every pushed word and on every round
  assign sched_ctrl.shift = push || rnd_stat.active;
  assign sched_ctrl.load  = push;
  assign sched_ctrl.word  = push_word;

  assign rnd_ctrl.start = wrap;
  assign rnd_ctrl.init  = out_acc && idx_q == sha256md_pkg::IdxLast;

  sha256md_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .wt_o   (wt)
  );

  sha256md_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rnd_ctrl),
    .wt_i   (wt),
    .stat_o (rnd_stat),
    .hash_o (hash)
  );

  assign digest_word_o = hash[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == sha256md_pkg::IdxLast);

endmodule

>>> bench/tb_sha256_message_digest_top.sv
`timescale 1ns / 1ps

module tb_sha256_message_digest_top;

  typedef struct packed {
    logic [31:0]  word;
    logic [5:0]   vbits;
    logic         fin;
    logic         has_known;
    logic [255:0] known;
  } msg_row_t;

  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  idx;
    logic        lastw;
  } digest_item_t;

  localparam int NumRows = 11;
  localparam int RandWords = 320;

  // directed rows; known digests of the empty message and of "abc" head the table
  localparam msg_row_t DirRows [NumRows] = '{
    '{32'h0000_0000, 6'd0, 1'b1, 1'b1,
      256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855},
    '{32'h6162_6300, 6'd24, 1'b1, 1'b1,
      256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad},
    '{32'hffff_ffff, 6'd32, 1'b1, 1'b0, 256'h0},
    '{32'hffff_ffff, 6'd63, 1'b1, 1'b0, 256'h0},
    '{32'hffff_ffff, 6'd1,  1'b1, 1'b0, 256'h0},
    '{32'hffff_ffff, 6'd31, 1'b1, 1'b0, 256'h0},
    '{32'haaaa_aaaa, 6'd5,  1'b0, 1'b0, 256'h0},
    '{32'h5555_5555, 6'd40, 1'b0, 1'b0, 256'h0},
    '{32'h1234_5678, 6'd16, 1'b1, 1'b0, 256'h0},
    '{32'h0000_0000, 6'd32, 1'b0, 1'b0, 256'h0},
    '{32'hdead_beef, 6'd0,  1'b1, 1'b0, 256'h0}
  };

  localparam logic [31:0] RndK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] word_i = '0;
  logic [5:0]  valid_bits_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_message_digest_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .word_i        (word_i),
    .valid_bits_i  (valid_bits_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] hash_state [8];
  logic [31:0] msg_sched [16];
  logic [3:0]  sched_fill;
  logic [63:0] msg_len_bits;

  digest_item_t digest_q [$];

  int tx_idle_pct = 13;
  int rx_idle_pct = 71;
  bit squeeze_req = 1'b0;
  bit squeeze_rx = 1'b0;
  int n_errors = 0;
  int n_words = 0;
  int n_msgs = 0;
  int n_checked = 0;

  function automatic logic [31:0] rot_r(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = StartHash[i];
    sched_fill = '0;
    msg_len_bits = '0;
  endtask

  task automatic compress_block();
    logic [31:0] v [8];
    logic [31:0] wt, w2, w15, t1, t2;
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = msg_sched[t];
      end else begin
        w2  = msg_sched[(t - 2) % 16];
        w15 = msg_sched[(t - 15) % 16];
        wt = (rot_r(w2, 17) ^ rot_r(w2, 19) ^ (w2 >> 10)) + msg_sched[(t - 7) % 16]
           + (rot_r(w15, 7) ^ rot_r(w15, 18) ^ (w15 >> 3)) + msg_sched[t % 16];
        msg_sched[t % 16] = wt;
      end
      t1 = v[7] + (rot_r(v[4], 6) ^ rot_r(v[4], 11) ^ rot_r(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RndK[t] + wt;
      t2 = (rot_r(v[0], 2) ^ rot_r(v[0], 13) ^ rot_r(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endtask

  task automatic absorb_word(input logic [31:0] w);
    msg_sched[sched_fill] = w;
    sched_fill = sched_fill + 4'd1;
    if (sched_fill == 4'd0) compress_block();
  endtask

  // returns the digest in dig when fin closes the message
  task automatic predict_digest(input logic [31:0] w, input logic [5:0] vb, input logic fin,
                                output logic [31:0] dig [8]);
    logic [5:0] nbits;
    nbits = (vb > 6'd32 || !fin) ? 6'd32 : vb;
    msg_len_bits = msg_len_bits + 64'(nbits);
    if (!fin) begin
      absorb_word(w);
    end else begin
      if (nbits == 6'd32) begin
        absorb_word(w);
        absorb_word(32'h8000_0000);
      end else begin
        // drop bits past the valid count, then the pad one right after them
        absorb_word((w & ~(32'hffff_ffff >> nbits)) | (32'h8000_0000 >> nbits));
      end
      while (sched_fill != 4'd14) absorb_word(32'h0);
      absorb_word(msg_len_bits[63:32]);
      absorb_word(msg_len_bits[31:0]);
      for (int i = 0; i < 8; i++) dig[i] = hash_state[i];
      restart_message();
    end
  endtask

  task automatic send_word(input msg_row_t row);
    logic [31:0] dig [8];
    digest_item_t item;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    word_i       <= row.word;
    valid_bits_i <= row.vbits;
    last_i       <= row.fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_words++;
    predict_digest(row.word, row.vbits, row.fin, dig);
    if (row.fin) begin
      n_msgs++;
      for (int i = 0; i < 8; i++) begin
        item.digest = row.has_known ? row.known[255 - 32 * i -: 32] : dig[i];
        item.idx    = 3'(i);
        item.lastw  = (i == 7);
        digest_q.push_back(item);
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= squeeze_rx ? 1'b0 : ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // long receiver hold so the block backs up onto its input
  initial begin
    wait (squeeze_req);
    @(posedge clk_i);
    squeeze_rx = 1'b1;
    repeat (700) @(posedge clk_i);
    squeeze_rx = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        $error("digest item with nothing expected: word %h index %0d", digest_word_o,
               word_index_o);
        n_errors++;
      end else begin
        automatic digest_item_t exp_item = digest_q.pop_front();
        n_checked++;
        if (digest_word_o !== exp_item.digest) begin
          $error("digest_word: expected %h, got %h", exp_item.digest, digest_word_o);
          n_errors++;
        end
        if (word_index_o !== exp_item.idx) begin
          $error("word_index: expected %0d, got %0d", exp_item.idx, word_index_o);
          n_errors++;
        end
        if (last_word_o !== exp_item.lastw) begin
          $error("last_word: expected %0d, got %0d", exp_item.lastw, last_word_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    msg_row_t row;
    int rand_words;
    int msg_len;
    int guard;
    rand_words = 0;
    guard = 0;
    for (int i = 0; i < 16; i++) msg_sched[i] = '0;
    restart_message();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NumRows; r++) send_word(DirRows[r]);

    while (rand_words < RandWords) begin
      if (rand_words >= 2 * RandWords / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        squeeze_req = 1'b1;
      end else if (rand_words >= RandWords / 3) begin
        tx_idle_pct = 71;
        rx_idle_pct = 13;
      end
      // mostly short messages, now and then a few blocks long
      msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
      if (msg_len > RandWords - rand_words) msg_len = RandWords - rand_words;
      for (int k = 0; k < msg_len; k++) begin
        row.word      = $urandom;
        row.fin       = (k == msg_len - 1);
        row.has_known = 1'b0;
        row.known     = '0;
        if (row.fin) begin
          row.vbits = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                  : 6'($urandom_range(0, 32));
        end else begin
          row.vbits = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) : 6'd32;
        end
        send_word(row);
        rand_words++;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (digest_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (digest_q.size() != 0) begin
      $error("%0d digest items never came out", digest_q.size());
      n_errors++;
    end
    repeat (100) @(posedge clk_i);

    $display("hashed %0d messages from %0d words, %0d digest items compared",
             n_msgs, n_words, n_checked);
    $display("mixed sender and receiver stalls, a long output hold, partial and empty tails");
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
